// ===== design/knp_pkg.sv =====
package knp_pkg;

   localparam int PORT_COORD_BITS = 16;
   localparam int SQ_BITS         = 33;
   localparam int RANK_BITS       = 6;
   localparam int WANT_BITS       = 7;
   localparam int MAX_RESULTS     = 64;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_QUERY = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

// ===== design/knp_store.sv =====
// Point memory: one write port for loads, one registered read port for scans.
module knp_store
   import knp_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int COORD_BITS = 16,
   localparam int AW        = $clog2(CAPACITY)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [PORT_COORD_BITS-1:0]  wr_x,
   input  logic [PORT_COORD_BITS-1:0]  wr_y,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic                        rd_valid,
   output logic [AW-1:0]               rd_idx,
   output logic [COORD_BITS-1:0]       rd_x,
   output logic [COORD_BITS-1:0]       rd_y
);

   logic [2*COORD_BITS-1:0] mem [CAPACITY];
   logic [2*COORD_BITS-1:0] rd_data_ff;
   logic [AW-1:0]           rd_idx_ff;
   logic                    rd_valid_ff;
   logic [31:0]             wx32;
   logic [31:0]             wy32;

   // narrow coordinates keep the field's low bits; wide ones see it as unsigned
   assign wx32 = {16'b0, wr_x};
   assign wy32 = {16'b0, wr_y};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wx32[COORD_BITS-1:0], wy32[COORD_BITS-1:0]};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_idx   = rd_idx_ff;
   assign rd_x     = rd_data_ff[2*COORD_BITS-1:COORD_BITS];
   assign rd_y     = rd_data_ff[COORD_BITS-1:0];

endmodule

// ===== design/knp_dist.sv =====
// Three-stage squared distance: abs difference, squares, sum.
module knp_dist
#(
   parameter int CAPACITY   = 64,
   parameter int COORD_BITS = 16,
   localparam int AW        = $clog2(CAPACITY),
   localparam int SW        = 2*COORD_BITS + 1,
   localparam int DW        = (SW > 64) ? 64 : SW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [AW-1:0]         in_idx,
   input  logic [COORD_BITS-1:0] in_x,
   input  logic [COORD_BITS-1:0] in_y,
   input  logic [COORD_BITS-1:0] qx,
   input  logic [COORD_BITS-1:0] qy,
   output logic                  out_valid,
   output logic [AW-1:0]         out_idx,
   output logic [COORD_BITS-1:0] out_x,
   output logic [COORD_BITS-1:0] out_y,
   output logic [DW-1:0]         out_dist
);

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic signed [COORD_BITS:0] abs_x;
   logic signed [COORD_BITS:0] abs_y;
   logic [SW-1:0]              sum;

   logic [2:0]                 valid_ff;
   logic [AW-1:0]              idx_ff [3];
   logic [COORD_BITS-1:0]      x_ff [3];
   logic [COORD_BITS-1:0]      y_ff [3];
   logic [COORD_BITS-1:0]      ax_ff;
   logic [COORD_BITS-1:0]      ay_ff;
   logic [2*COORD_BITS-1:0]    sqx_ff;
   logic [2*COORD_BITS-1:0]    sqy_ff;
   logic [DW-1:0]              dist_ff;

   always_comb begin
      dx    = $signed({in_x[COORD_BITS-1], in_x}) - $signed({qx[COORD_BITS-1], qx});
      dy    = $signed({in_y[COORD_BITS-1], in_y}) - $signed({qy[COORD_BITS-1], qy});
      abs_x = dx[COORD_BITS] ? -dx : dx;
      abs_y = dy[COORD_BITS] ? -dy : dy;
      sum   = SW'(sqx_ff) + SW'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      idx_ff[0] <= in_idx;
      x_ff[0]   <= in_x;
      y_ff[0]   <= in_y;
      ax_ff     <= abs_x[COORD_BITS-1:0];
      ay_ff     <= abs_y[COORD_BITS-1:0];
      idx_ff[1] <= idx_ff[0];
      x_ff[1]   <= x_ff[0];
      y_ff[1]   <= y_ff[0];
      sqx_ff    <= ax_ff * ax_ff;
      sqy_ff    <= ay_ff * ay_ff;
      idx_ff[2] <= idx_ff[1];
      x_ff[2]   <= x_ff[1];
      y_ff[2]   <= y_ff[1];
      // wide coordinates wrap at 64 bits
      dist_ff   <= sum[DW-1:0];
   end

   assign out_valid = valid_ff[2];
   assign out_idx   = idx_ff[2];
   assign out_x     = x_ff[2];
   assign out_y     = y_ff[2];
   assign out_dist  = dist_ff;

endmodule

// ===== design/k_nearest_points_2d.sv =====
// channel   dir  handshake            payload
// req       in   req_valid/req_ready  opcode, point_x, point_y, want_count
// rsp       out  rsp_valid/rsp_ready  near_x, near_y, sq_distance, rank, last_item
//
// Load and clear complete without leaving idle; a full store drops the load.
// A query with k results makes k passes over the point memory: each pass reads
// all n stored points through the registered read port and the distance
// pipeline, then loads the next-nearest point into the output register.
// Reset clears point count and control state; the memory itself is never swept.
// A held result stalls only the emit at the end of the next pass; req is taken
// only between queries.
module k_nearest_points_2d
   import knp_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic signed [PORT_COORD_BITS-1:0]  req_point_x,
   input  logic signed [PORT_COORD_BITS-1:0]  req_point_y,
   input  logic [WANT_BITS-1:0]               req_want_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [PORT_COORD_BITS-1:0]  rsp_near_x,
   output logic signed [PORT_COORD_BITS-1:0]  rsp_near_y,
   output logic [SQ_BITS-1:0]                 rsp_sq_distance,
   output logic [RANK_BITS-1:0]               rsp_rank,
   output logic                               rsp_last_item
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = (CW > WANT_BITS) ? CW : WANT_BITS;
   localparam int SW = 2*COORD_BITS + 1;
   localparam int DW = (SW > 64) ? 64 : SW;
   localparam int XW = (DW > SQ_BITS) ? DW : SQ_BITS;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          issue_ff, issue_in;
   logic [WANT_BITS-1:0]   k_ff, k_in;
   logic [WANT_BITS-1:0]   r_ff, r_in;
   logic                   found_ff, found_in;
   logic                   have_prev_ff, have_prev_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [COORD_BITS-1:0]  qx_ff, qy_ff;
   logic [DW-1:0]          best_d_ff, prev_d_ff;
   logic [AW-1:0]          best_idx_ff, prev_idx_ff;
   logic [COORD_BITS-1:0]  best_x_ff, best_y_ff;
   logic [PORT_COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [SQ_BITS-1:0]     rsp_d_ff;
   logic [RANK_BITS-1:0]   rsp_rank_ff;
   logic                   rsp_last_ff;

   logic                   wr_en, rd_en;
   logic                   load_query, take_best, load_rsp;
   logic                   dist_valid;
   logic [AW-1:0]          dist_idx, rd_idx;
   logic                   rd_valid;
   logic [COORD_BITS-1:0]  rd_x, rd_y, dist_x, dist_y;
   logic [DW-1:0]          dist_d;
   logic                   qualifies, better, last_round;
   logic [WANT_BITS-1:0]   cap_k, k_calc;
   logic [31:0]            qx32, qy32, near_x32, near_y32;
   logic [XW-1:0]          best_d_ext;

   knp_store #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[AW-1:0]),
      .wr_x     (req_point_x),
      .wr_y     (req_point_y),
      .rd_en    (rd_en),
      .rd_addr  (issue_ff[AW-1:0]),
      .rd_valid (rd_valid),
      .rd_idx   (rd_idx),
      .rd_x     (rd_x),
      .rd_y     (rd_y)
   );

   knp_dist #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid),
      .in_idx    (rd_idx),
      .in_x      (rd_x),
      .in_y      (rd_y),
      .qx        (qx_ff),
      .qy        (qy_ff),
      .out_valid (dist_valid),
      .out_idx   (dist_idx),
      .out_x     (dist_x),
      .out_y     (dist_y),
      .out_dist  (dist_d)
   );

   always_comb begin
      qx32 = {16'b0, req_point_x};
      qy32 = {16'b0, req_point_y};

      // k = min(want, stored points, result limit)
      cap_k  = (MW'(count_ff) > MW'(MAX_RESULTS)) ? WANT_BITS'(MAX_RESULTS)
                                                  : WANT_BITS'(count_ff);
      k_calc = (req_want_count < cap_k) ? req_want_count : cap_k;

      // each pass takes the least (distance, index) above the last one reported
      qualifies = !have_prev_ff || (dist_d > prev_d_ff)
                  || ((dist_d == prev_d_ff) && (dist_idx > prev_idx_ff));
      better    = qualifies && (!found_ff || (dist_d < best_d_ff));
      last_round = (WANT_BITS'(r_ff + 1'b1) == k_ff);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      found_in     = found_ff;
      have_prev_in = have_prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      load_query   = 1'b0;
      take_best    = 1'b0;
      load_rsp     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (opcode_type'(req_opcode))
                  OP_LOAD: begin
                     if (count_ff < CW'(CAPACITY)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_QUERY: begin
                     load_query   = 1'b1;
                     k_in         = k_calc;
                     r_in         = '0;
                     issue_in     = '0;
                     found_in     = 1'b0;
                     have_prev_in = 1'b0;
                     if (k_calc != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_en = (issue_ff < count_ff);
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
            end
            if (dist_valid) begin
               if (better) begin
                  take_best = 1'b1;
                  found_in  = 1'b1;
               end
               if (CW'(dist_idx) == CW'(count_ff - 1'b1)) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               have_prev_in = 1'b1;
               found_in     = 1'b0;
               issue_in     = '0;
               r_in         = r_ff + 1'b1;
               state_in     = last_round ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_ff     <= '0;
         k_ff         <= '0;
         r_ff         <= '0;
         found_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         k_ff         <= k_in;
         r_ff         <= r_in;
         found_ff     <= found_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      near_x32   = 32'($signed(best_x_ff));
      near_y32   = 32'($signed(best_y_ff));
      best_d_ext = XW'(best_d_ff);
   end

   always_ff @(posedge clock) begin
      if (load_query) begin
         qx_ff <= qx32[COORD_BITS-1:0];
         qy_ff <= qy32[COORD_BITS-1:0];
      end
      if (take_best) begin
         best_d_ff   <= dist_d;
         best_idx_ff <= dist_idx;
         best_x_ff   <= dist_x;
         best_y_ff   <= dist_y;
      end
      if (load_rsp) begin
         prev_d_ff   <= best_d_ff;
         prev_idx_ff <= best_idx_ff;
         rsp_x_ff    <= near_x32[PORT_COORD_BITS-1:0];
         rsp_y_ff    <= near_y32[PORT_COORD_BITS-1:0];
         rsp_d_ff    <= best_d_ext[SQ_BITS-1:0];
         rsp_rank_ff <= r_ff[RANK_BITS-1:0];
         rsp_last_ff <= last_round;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_near_x      = rsp_x_ff;
   assign rsp_near_y      = rsp_y_ff;
   assign rsp_sq_distance = rsp_d_ff;
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_last_item   = rsp_last_ff;

endmodule
